>>> design/text_cell_pixel_generator_macros.svh
// assertion macros used by the text cell pixel generator rtl
// no dependencies; bodies vanish when SYNTHESIS is defined
`ifndef TEXT_CELL_PIXEL_GENERATOR_MACROS_SVH
`define TEXT_CELL_PIXEL_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define TCPG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcpg: same-cycle check failed");
// consequent must hold in the cycle after the antecedent
`define TCPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcpg: next-cycle check failed");
`else
`define TCPG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TCPG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/tcpg_pkg.sv
// types and constants of the text cell pixel generator
// no dependencies
package tcpg_pkg;

    localparam int PIX_PER_SLICE = 8;
    localparam int COLOUR_W      = 16;
    localparam int PAL_DEPTH     = 8;
    localparam int PAL_AW        = 3;

    localparam logic [3:0] UNDERLINE_ROW = 4'd10;
    localparam logic [2:0] RST_DEF_FG    = 3'd2;
    localparam logic [2:0] RST_DEF_BG    = 3'd0;

    typedef enum logic [1:0] {
        MODE_RENDER   = 2'd0,
        MODE_FONT_LD  = 2'd1,
        MODE_PAL_LD   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REG_ATTR_MODE = 2'd0,
        REG_DEF_FG    = 2'd1,
        REG_DEF_BG    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic       attr_mode;
        logic [2:0] def_fg;
        logic [2:0] def_bg;
    } t_cfg;

    // per-item control carried beside the store reads
    typedef struct packed {
        logic       semi;
        logic [7:0] semi_bits;
        logic       invert;
        logic       row_oob;
        logic       underline;
    } t_meta;

    typedef logic [PIX_PER_SLICE-1:0][COLOUR_W-1:0] t_slice;

endpackage

>>> design/tcpg_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module tcpg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/tcpg_cfg.sv
// apb-style configuration registers of the text cell pixel generator
// depends on tcpg_pkg
module tcpg_cfg
    import tcpg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign w_wr  = psel && penable && pwrite;
    assign w_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attr_mode <= 1'b0;
            r_cfg.def_fg    <= RST_DEF_FG;
            r_cfg.def_bg    <= RST_DEF_BG;
        end else if (w_wr) begin
            case (w_idx)
                REG_ATTR_MODE: r_cfg.attr_mode <= pwdata[0];
                REG_DEF_FG:    r_cfg.def_fg    <= pwdata[2:0];
                REG_DEF_BG:    r_cfg.def_bg    <= pwdata[2:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ATTR_MODE: prdata = {31'd0, r_cfg.attr_mode};
            REG_DEF_FG:    prdata = {29'd0, r_cfg.def_fg};
            REG_DEF_BG:    prdata = {29'd0, r_cfg.def_bg};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/tcpg_shade.sv
// turns a glyph row, underline or semigraphics pattern into eight palette colours
// depends on tcpg_pkg
module tcpg_shade
    import tcpg_pkg::*;
(
    input  t_meta                i_meta,
    input  logic [7:0]           i_font_row,
    input  logic [COLOUR_W-1:0]  i_fg,
    input  logic [COLOUR_W-1:0]  i_bg,
    output t_slice               o_pix
);

    logic [7:0] w_glyph;
    logic [7:0] w_bits;

    always_comb begin
        w_glyph = i_meta.row_oob ? 8'h00 : i_font_row;
        if (i_meta.semi) begin
            w_bits = i_meta.semi_bits;
        end else if (i_meta.underline) begin
            w_bits = 8'hFF;
        end else begin
            w_bits = w_glyph ^ {8{i_meta.invert}};
        end
    end

    // pixel k follows glyph bit 7-k
    always_comb begin
        for (int k = 0; k < PIX_PER_SLICE; k++) begin
            o_pix[k] = w_bits[PIX_PER_SLICE-1-k] ? i_fg : i_bg;
        end
    end

endmodule

>>> design/text_cell_pixel_generator.sv
// text cell pixel generator: one 8-pixel slice of a character cell per beat
// pipeline: a render's store reads register into stage 1, its pixels into the output register
// throughput: one beat per cycle, renders and loads alike, unless a full stage 1 is stalled
// loads give no result; a load is seen by the very next render
// reset: config registers to defaults and pipeline valid bits clear synchronously
// the font and palette stores are not cleared and hold nothing defined until loaded
`include "text_cell_pixel_generator_macros.svh"

module text_cell_pixel_generator
    import tcpg_pkg::*;
#(
    parameter int GLYPH_ROWS  = 12,
    parameter int GLYPH_COUNT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // input beats
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_attribute,
    input  logic [3:0]  i_sub_row,
    input  logic [10:0] i_load_index,
    input  logic [15:0] i_load_value,

    // result beats
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_pixel_0,
    output logic [15:0] o_pixel_1,
    output logic [15:0] o_pixel_2,
    output logic [15:0] o_pixel_3,
    output logic [15:0] o_pixel_4,
    output logic [15:0] o_pixel_5,
    output logic [15:0] o_pixel_6,
    output logic [15:0] o_pixel_7,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);

    // handshake and pipeline control
    logic   w_in_accept;
    logic   w_render;
    logic   w_s1_move;
    logic   r_s1_valid;
    logic   r_out_valid;

    t_cfg   w_cfg;
    t_meta  n_meta;
    t_meta  r_s1_meta;

    // store ports
    logic               w_font_we;
    logic [FONT_AW-1:0] w_font_raddr;
    logic [7:0]         w_font_row;
    logic               w_pal_we;
    logic [PAL_AW-1:0]  n_fg_idx;
    logic [PAL_AW-1:0]  n_bg_idx;
    logic [COLOUR_W-1:0] w_fg;
    logic [COLOUR_W-1:0] w_bg;

    t_slice w_pix;
    t_slice r_out_pix;

    assign pready = 1'b1;

    tcpg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    // the stage 1 register moves on when the output register is free or being emptied;
    // a new beat comes in whenever stage 1 is empty or moving on
    assign w_s1_move   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || w_s1_move;
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_render    = w_in_accept && (i_mode == MODE_RENDER);

    // loads write at the accept edge, so a render right behind reads the new value
    assign w_font_we = w_in_accept && (i_mode == MODE_FONT_LD)
                       && (32'(i_load_index) < FONT_DEPTH);
    assign w_pal_we  = w_in_accept && (i_mode == MODE_PAL_LD)
                       && (i_load_index[10:PAL_AW] == '0);

    // stage 0: glyph address, palette indices and the per-cell control bits
    always_comb begin
        n_meta.row_oob = !(32'(i_sub_row) < GLYPH_ROWS);
        // rows past the glyph read as zero, so the address is parked at zero
        if (n_meta.row_oob) begin
            w_font_raddr = '0;
        end else begin
            w_font_raddr = FONT_AW'(i_char_code[6:0]) * FONT_AW'(GLYPH_ROWS)
                           + FONT_AW'(i_sub_row);
        end

        if (w_cfg.attr_mode) begin
            n_fg_idx = i_attribute[2:0];
            n_bg_idx = i_attribute[6:4];
        end else begin
            n_fg_idx = w_cfg.def_fg;
            n_bg_idx = w_cfg.def_bg;
        end

        n_meta.semi      = w_cfg.attr_mode && i_attribute[7];
        n_meta.invert    = i_char_code[7];
        n_meta.underline = w_cfg.attr_mode && i_attribute[3]
                           && (i_sub_row == UNDERLINE_ROW);

        // 2x3 block graphics: top, middle, bottom third each take a bit pair,
        // left block in the upper bit; rows 12 to 15 show background only
        case (i_sub_row[3:2])
            2'd0:    n_meta.semi_bits = {{4{i_char_code[5]}}, {4{i_char_code[4]}}};
            2'd1:    n_meta.semi_bits = {{4{i_char_code[3]}}, {4{i_char_code[2]}}};
            2'd2:    n_meta.semi_bits = {{4{i_char_code[1]}}, {4{i_char_code[0]}}};
            default: n_meta.semi_bits = 8'h00;
        endcase
    end

    // font store, one byte per glyph row
    tcpg_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (w_font_we),
        .i_waddr (FONT_AW'(i_load_index)),
        .i_wdata (i_load_value[7:0]),
        .i_re    (w_render),
        .i_raddr (w_font_raddr),
        .o_rdata (w_font_row)
    );

    // palette kept twice so foreground and background read in the same cycle
    tcpg_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (PAL_DEPTH)
    ) u_pal_fg_ram (
        .i_clk   (i_clk),
        .i_we    (w_pal_we),
        .i_waddr (i_load_index[PAL_AW-1:0]),
        .i_wdata (i_load_value),
        .i_re    (w_render),
        .i_raddr (n_fg_idx),
        .o_rdata (w_fg)
    );

    tcpg_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (PAL_DEPTH)
    ) u_pal_bg_ram (
        .i_clk   (i_clk),
        .i_we    (w_pal_we),
        .i_waddr (i_load_index[PAL_AW-1:0]),
        .i_wdata (i_load_value),
        .i_re    (w_render),
        .i_raddr (n_bg_idx),
        .o_rdata (w_bg)
    );

    // stage 1: read data is held in the rams while stalled, as read enable only
    // fires on an accepted render
    tcpg_shade u_shade (
        .i_meta     (r_s1_meta),
        .i_font_row (w_font_row),
        .i_fg       (w_fg),
        .i_bg       (w_bg),
        .o_pix      (w_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= w_render;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_render) begin
            r_s1_meta <= n_meta;
        end
        if (w_s1_move) begin
            r_out_pix <= w_pix;
        end
    end

    // output register
    assign o_out_valid = r_out_valid;
    assign o_pixel_0   = r_out_pix[0];
    assign o_pixel_1   = r_out_pix[1];
    assign o_pixel_2   = r_out_pix[2];
    assign o_pixel_3   = r_out_pix[3];
    assign o_pixel_4   = r_out_pix[4];
    assign o_pixel_5   = r_out_pix[5];
    assign o_pixel_6   = r_out_pix[6];
    assign o_pixel_7   = r_out_pix[7];

    // a stalled stage 1 must hold off new beats
    `TCPG_ASSERT_SAME(a_s1_stall_blocks_input, i_clk, i_rst_n, r_s1_valid && !w_s1_move, !o_in_ready)
    // an accepted render occupies stage 1 on the next cycle
    `TCPG_ASSERT_NEXT(a_render_fills_s1, i_clk, i_rst_n, w_render, r_s1_valid)
    // an accepted load leaves stage 1 empty, so it never yields a result
    `TCPG_ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n, w_in_accept && !w_render, !r_s1_valid)
    // whatever leaves stage 1 lands in the output register
    `TCPG_ASSERT_NEXT(a_s1_move_fills_out, i_clk, i_rst_n, w_s1_move, o_out_valid)

endmodule

>>> test/testbench.sv
// self-checking testbench of text_cell_pixel_generator: glyph and palette loads, renders, config
// depends on tcpg_pkg and the text_cell_pixel_generator rtl; a built-in predictor checks pixels
module testbench;
    import tcpg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GLYPH_ROWS   = 12;
    localparam int GLYPH_COUNT  = 128;
    localparam int FONT_DEPTH   = GLYPH_COUNT * GLYPH_ROWS;
    localparam int MAX_INDEX    = 2047;   // top of the 11-bit load index
    localparam int DRAIN_CYCLES = 4;      // lets the pipeline empty behind the last beat, with margin
    localparam int LIMIT_CYCLES = 100000;
    localparam int MAX_REPORTS  = 40;
    localparam int RAND_PER_SET = 68;

    // mode 3 has no member in the package enum
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // one input beat, as it sits on the input ports
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  code;
        logic [7:0]  attr;
        logic [3:0]  row;
        logic [10:0] idx;
        logic [15:0] val;
    } t_cell_beat;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // input channel
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_mode       = MODE_RENDER;
    logic [7:0]  i_char_code  = '0;
    logic [7:0]  i_attribute  = '0;
    logic [3:0]  i_sub_row    = '0;
    logic [10:0] i_load_index = '0;
    logic [15:0] i_load_value = '0;

    // result channel
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [15:0] o_pixel_0, o_pixel_1, o_pixel_2, o_pixel_3;
    logic [15:0] o_pixel_4, o_pixel_5, o_pixel_6, o_pixel_7;

    // register port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state: our own copy of both stores and of the registers
    logic [7:0]  font_mem [FONT_DEPTH];
    logic [15:0] pal_mem  [PAL_DEPTH];
    t_cfg        cfg;

    // stimulus bookkeeping: which glyph rows have been loaded so far, in beat order
    bit          font_seen [FONT_DEPTH];
    int          seen_rows [$];

    t_cell_beat  beat_queue [$];
    t_cell_beat  cur_beat;
    t_slice      pending_slices [$];

    bit in_taken   = 1'b0;
    bit steady     = 1'b0;   // no idling on either side once set
    int gap_left   = 0;
    int stall_left = 0;

    int cycles         = 0;
    int errors         = 0;
    int beats_queued   = 0;
    int beats_taken    = 0;
    int slices_checked = 0;
    int loads_taken    = 0;
    int beats_ignored  = 0;
    int settings_used  = 0;

    text_cell_pixel_generator #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_attribute  (i_attribute),
        .i_sub_row    (i_sub_row),
        .i_load_index (i_load_index),
        .i_load_value (i_load_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_0    (o_pixel_0),
        .o_pixel_1    (o_pixel_1),
        .o_pixel_2    (o_pixel_2),
        .o_pixel_3    (o_pixel_3),
        .o_pixel_4    (o_pixel_4),
        .o_pixel_5    (o_pixel_5),
        .o_pixel_6    (o_pixel_6),
        .o_pixel_7    (o_pixel_7),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor: applies one accepted beat to the store copies and, for a
    // render, works out the eight colours of the slice
    // ------------------------------------------------------------------
    task automatic predict_pixels(input t_cell_beat b);
        logic [2:0]  fg_sel;
        logic [2:0]  bg_sel;
        logic [15:0] fg;
        logic [15:0] bg;
        logic [7:0]  bits;
        logic [2:0]  shift;
        logic        left;
        logic        right;
        t_slice      px;
        case (b.mode)
            MODE_FONT_LD: begin
                // loads beyond the font are dropped
                if (b.idx < FONT_DEPTH) begin
                    font_mem[b.idx] = b.val[7:0];
                    loads_taken++;
                end else begin
                    beats_ignored++;
                end
            end
            MODE_PAL_LD: begin
                if (b.idx < PAL_DEPTH) begin
                    pal_mem[b.idx[2:0]] = b.val;
                    loads_taken++;
                end else begin
                    beats_ignored++;
                end
            end
            MODE_RENDER: begin
                // colour pair: from the attribute byte, or the default registers
                if (cfg.attr_mode) begin
                    fg_sel = b.attr[2:0];
                    bg_sel = b.attr[6:4];
                end else begin
                    fg_sel = cfg.def_fg;
                    bg_sel = cfg.def_bg;
                end
                fg = pal_mem[fg_sel];
                bg = pal_mem[bg_sel];
                if (cfg.attr_mode && b.attr[7]) begin
                    // 2x3 blocks: sub_row picks the third, rows 12-15 fall off the bottom
                    shift = {b.row[3:2], 1'b0};
                    left  = |(b.code & (8'h20 >> shift));
                    right = |(b.code & (8'h10 >> shift));
                    bits  = {{4{left}}, {4{right}}};
                end else begin
                    // rows past the glyph read as blank
                    if (b.row < GLYPH_ROWS)
                        bits = font_mem[int'(b.code[6:0]) * GLYPH_ROWS + int'(b.row)];
                    else
                        bits = 8'h00;
                    if (b.code[7])
                        bits = ~bits;
                    if (cfg.attr_mode && b.attr[3] && b.row == UNDERLINE_ROW)
                        bits = 8'hFF;
                end
                // pixel 0 is the leftmost, driven by glyph bit 7
                for (int k = 0; k < PIX_PER_SLICE; k++)
                    px[k] = bits[7 - k] ? fg : bg;
                pending_slices.push_back(px);
            end
            default: beats_ignored++;
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function automatic t_cell_beat random_beat();
        t_cell_beat b;
        b.mode = MODE_UNUSED;
        b.code = 8'($urandom);
        b.attr = 8'($urandom);
        b.row  = 4'($urandom);
        b.idx  = 11'($urandom);
        b.val  = 16'($urandom);
        return b;
    endfunction

    function automatic void push_beat(input t_cell_beat b);
        // remember loaded glyph rows so that renders only read defined bytes
        if (b.mode == MODE_FONT_LD && b.idx < FONT_DEPTH && !font_seen[b.idx]) begin
            font_seen[b.idx] = 1'b1;
            seen_rows.push_back(int'(b.idx));
        end
        beat_queue.push_back(b);
        beats_queued++;
    endfunction

    function automatic void queue_load(input logic [1:0] m, input int idx,
                                       input logic [15:0] val);
        t_cell_beat b;
        b      = random_beat();
        b.mode = m;
        b.idx  = 11'(idx);
        b.val  = val;
        push_beat(b);
    endfunction

    function automatic void queue_render(input logic [7:0] code, input logic [7:0] attr,
                                         input logic [3:0] row);
        t_cell_beat b;
        b      = random_beat();
        b.mode = MODE_RENDER;
        b.code = code;
        b.attr = attr;
        b.row  = row;
        push_beat(b);
    endfunction

    // random traffic: font and palette loads, renders that read loaded rows back, unused-mode beats
    task automatic queue_random(input int n);
        int         a;
        int         pick;
        logic       ul;
        logic [7:0] at;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            at   = 8'($urandom);
            if (pick < 25) begin
                // fresh glyph row, drawn straight after; underline rows favoured in attr mode
                a  = $urandom_range(0, FONT_DEPTH - 1);
                ul = cfg.attr_mode && ($urandom_range(0, 2) == 0);
                if (ul)
                    a = $urandom_range(0, GLYPH_COUNT - 1) * GLYPH_ROWS + UNDERLINE_ROW;
                at[7] = 1'b0;
                at[3] = at[3] | ul;
                queue_load(MODE_FONT_LD, a, 16'($urandom));
                queue_render({1'($urandom), 7'(a / GLYPH_ROWS)}, at, 4'(a % GLYPH_ROWS));
            end else if (pick < 60) begin
                if (cfg.attr_mode && at[7]) begin
                    // semigraphics reads no font, so any code and row will do
                    queue_render(8'($urandom), at, 4'($urandom));
                end else if ($urandom_range(0, 6) == 0) begin
                    queue_render(8'($urandom), at, 4'($urandom_range(GLYPH_ROWS, 15)));
                end else begin
                    a = seen_rows[$urandom_range(0, seen_rows.size() - 1)];
                    queue_render({1'($urandom), 7'(a / GLYPH_ROWS)}, at, 4'(a % GLYPH_ROWS));
                end
            end else if (pick < 80) begin
                a = ($urandom_range(0, 9) == 0) ? $urandom_range(FONT_DEPTH, MAX_INDEX)
                                                : $urandom_range(0, FONT_DEPTH - 1);
                queue_load(MODE_FONT_LD, a, 16'($urandom));
            end else if (pick < 92) begin
                a = ($urandom_range(0, 4) == 0) ? $urandom_range(PAL_DEPTH, MAX_INDEX)
                                                : $urandom_range(0, PAL_DEPTH - 1);
                queue_load(MODE_PAL_LD, a, 16'($urandom));
            end else begin
                // unused mode, all other fields random
                push_beat(random_beat());
            end
        end
    endtask

    // wait for every queued beat to go in and every slice to come out
    task automatic drain();
        while (beats_taken != beats_queued || pending_slices.size() != 0)
            @(posedge i_clk);
        // loads give no result, so let the pipe empty behind the last one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write, then a read-back of the same register
    task automatic write_reg(input t_reg_idx r, input logic [31:0] v);
        logic [31:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        want = '0;
        case (r)
            REG_ATTR_MODE: begin
                cfg.attr_mode = v[0];
                want[0]       = v[0];
            end
            REG_DEF_FG: begin
                cfg.def_fg = v[2:0];
                want[2:0]  = v[2:0];
            end
            REG_DEF_BG: begin
                cfg.def_bg = v[2:0];
                want[2:0]  = v[2:0];
            end
            default: ;
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            errors++;
            $display("%0t: register %s read back, expected %h, got %h",
                     $time, r.name(), want, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // input driver: a beat is taken at a rising edge with valid and ready high,
    // the next one (or a gap) goes out at the following falling edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_pixels(cur_beat);
            beats_taken++;
            in_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        // valid only drops or moves on once the current beat has gone in
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (beat_queue.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                // idle gap of random length before the next beat
                gap_left = $urandom_range(0, 5);
                i_in_valid <= 1'b0;
            end else begin
                cur_beat = beat_queue.pop_front();
                i_in_valid   <= 1'b1;
                i_mode       <= cur_beat.mode;
                i_char_code  <= cur_beat.code;
                i_attribute  <= cur_beat.attr;
                i_sub_row    <= cur_beat.row;
                i_load_index <= cur_beat.idx;
                i_load_value <= cur_beat.val;
            end
        end
        in_taken = 1'b0;
    end

    // ------------------------------------------------------------------
    // result monitor: back-pressure in bursts, each slice checked pixel by pixel
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_slice got;
        t_slice want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_pixel_7, o_pixel_6, o_pixel_5, o_pixel_4,
                   o_pixel_3, o_pixel_2, o_pixel_1, o_pixel_0};
            if (pending_slices.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result beat with none expected, expected nothing, got %h",
                             $time, got);
            end else begin
                want = pending_slices.pop_front();
                slices_checked++;
                for (int k = 0; k < PIX_PER_SLICE; k++) begin
                    if (got[k] !== want[k]) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: pixel_%0d expected %h, got %h",
                                     $time, k, want[k], got[k]);
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycles < LIMIT_CYCLES)
            @(posedge i_clk);
        $display("%0t: timed out with %0d beats queued, %0d taken, %0d slices outstanding",
                 $time, beats_queued, beats_taken, pending_slices.size());
        $display("** text_cell_pixel_generator: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        t_cfg nxt;
        cfg = '{attr_mode: 1'b0, def_fg: RST_DEF_FG, def_bg: RST_DEF_BG};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset colours: whole palette first, black and white at the ends
        for (int p = 0; p < PAL_DEPTH; p++)
            queue_load(MODE_PAL_LD, p, (p == 0) ? 16'h0000 :
                                       (p == PAL_DEPTH - 1) ? 16'hFFFF : 16'($urandom));
        // font bytes keep only the low half of the load value
        queue_load(MODE_FONT_LD, 'h41 * GLYPH_ROWS, 16'hA581);
        queue_load(MODE_FONT_LD, 'h41 * GLYPH_ROWS + UNDERLINE_ROW, 16'h003C);
        queue_load(MODE_FONT_LD, 0, 16'h5AA5);
        queue_load(MODE_FONT_LD, FONT_DEPTH - 1, 16'hFF00);
        // loads past the end of either store are dropped
        queue_load(MODE_FONT_LD, FONT_DEPTH, 16'h00FF);
        queue_load(MODE_PAL_LD, MAX_INDEX, 16'h1234);
        push_beat(random_beat());
        queue_render(8'h41, 8'($urandom), 4'd0);
        queue_render(8'hC1, 8'($urandom), 4'd0);      // inverted glyph
        queue_render(8'h41, 8'($urandom), 4'd15);     // row past the glyph
        queue_render(8'hFF, 8'($urandom), 4'd11);     // last glyph row, inverted
        queue_render(8'h00, 8'($urandom), 4'd0);

        // five settings: both modes, colour indices at both ends, then a random one
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: nxt = '{attr_mode: 1'b1, def_fg: 3'd2, def_bg: 3'd0};
                1: nxt = '{attr_mode: 1'b0, def_fg: 3'd7, def_bg: 3'd0};
                2: nxt = '{attr_mode: 1'b0, def_fg: 3'd0, def_bg: 3'd7};
                3: nxt = '{attr_mode: 1'b1, def_fg: 3'd5, def_bg: 3'd3};
                default: begin
                    nxt.attr_mode = 1'($urandom);
                    nxt.def_fg    = 3'($urandom);
                    nxt.def_bg    = 3'($urandom);
                end
            endcase
            // sender holds off here until every slice has come back
            drain();
            write_reg(REG_ATTR_MODE, 32'(nxt.attr_mode));
            write_reg(REG_DEF_FG, 32'(nxt.def_fg));
            write_reg(REG_DEF_BG, 32'(nxt.def_bg));
            settings_used++;
            if (ph == 0) begin
                // attribute cells: underline on and off, semigraphics in every third
                queue_render(8'h41, 8'h0F, UNDERLINE_ROW);
                queue_render(8'hC1, 8'h70, UNDERLINE_ROW);
                queue_render(8'h26, 8'hB4, 4'd0);
                queue_render(8'h26, 8'hB4, 4'd6);
                queue_render(8'h26, 8'hBC, UNDERLINE_ROW);   // underline bit has no say here
                queue_render(8'h26, 8'hB4, 4'd14);           // below the bottom third
            end
            // last stretch runs flat out on both sides
            if (ph == 4)
                steady = 1'b1;
            queue_random(RAND_PER_SET);
        end
        drain();

        $display("checked %0d pixel slices over %0d beats; %0d store loads, %0d beats ignored",
                 slices_checked, beats_taken, loads_taken, beats_ignored);
        $display("register settings applied: %0d, mismatches: %0d", settings_used, errors);
        if (errors == 0)
            $display("** text_cell_pixel_generator: PASSED **");
        else
            $display("** text_cell_pixel_generator: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/tcpg_pkg.sv
design/tcpg_ram.sv
design/tcpg_cfg.sv
design/tcpg_shade.sv
design/text_cell_pixel_generator.sv
test/testbench.sv
